>>> rtl/calendar_date_stepper_defines.svh
// ----------------------------------------------------------------------------
// Calendar date stepper assertion macros
// Shared property shorthands for the checker, clocked on clk and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_STEPPER_DEFINES_SVH
`define CALENDAR_DATE_STEPPER_DEFINES_SVH

// Condition on the same edge implies a consequence on that edge.
`define CDS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar date stepper check failed");

// Condition on one edge implies a consequence on the next edge.
`define CDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar date stepper check failed");

`endif

>>> rtl/cds_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date stepper package
// Codes, command and status types, calendar tables and date functions shared
// by the controller, the datapath and the checker.
// ----------------------------------------------------------------------------
package cds_pkg;

    // Supported year range and the longest walk of one request.
    localparam logic [11:0] YEAR_MIN = 12'd1900;
    localparam logic [11:0] YEAR_MAX = 12'd2100;
    localparam logic [9:0]  MAX_STEP = 10'd1023;

    // Request codes.
    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_FWD  = 2'd1,
        OP_BACK = 2'd2,
        OP_CMP  = 2'd3
    } op_t;

    // Status codes of a result.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_YEAR    = 3'd1,
        ST_BAD_MONTH   = 3'd2,
        ST_DAY_OVER    = 3'd3,
        ST_DAY_INVALID = 3'd4,
        ST_RANGE_END   = 3'd5
    } status_t;

    // Relation of the stored date to a given one.
    typedef enum logic [1:0] {
        REL_EQ      = 2'd0,
        REL_EARLIER = 2'd1,
        REL_LATER   = 2'd2
    } rel_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_WALK   = 2'd2,
        S_FINISH = 2'd3
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture an accepted request
        logic exec;    // carry out a set or compare request
        logic walk;    // move the date one day
        logic finish;  // load the result register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;          // request being served
        logic steps_zero;  // no days left to walk
        logic blocked;     // the next day lies beyond the year range
        logic out_free;    // the result register can take a new result
    } dp_stat_t;

    // Days per month, February in a common year; unused codes read 0.
    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    // Zeller month term (13 * (m + 1)) / 5 for shifted months 3 to 14.
    localparam logic [5:0] ZELLER_MONTH [16] = '{
        6'd0, 6'd0, 6'd0, 6'd10, 6'd13, 6'd15, 6'd18, 6'd20,
        6'd23, 6'd26, 6'd28, 6'd31, 6'd33, 6'd36, 6'd39, 6'd0
    };

    // Leap year test for the supported range: the only century years
    // there are 1900 and 2100 (common) and 2000 (leap).
    function automatic logic is_leap(input logic [11:0] year);
        return (year[1:0] == 2'b00) && (year != YEAR_MIN) && (year != YEAR_MAX);
    endfunction

    function automatic logic [4:0] days_in(input logic [11:0] year,
                                           input logic [3:0]  month);
        if ((month == 4'd2) && is_leap(year))
            return 5'd29;
        return MONTH_LEN[month];
    endfunction

    // Zeller weekday, 0 Saturday through 6 Friday, for a stored date. The
    // century split uses compares since the shifted year lies in 1899..2100.
    function automatic logic [2:0] zeller_weekday(input logic [11:0] year,
                                                  input logic [3:0]  month,
                                                  input logic [4:0]  day);
        logic [11:0] y;
        logic [3:0]  m;
        logic [4:0]  c;
        logic [11:0] base;
        logic [6:0]  yy;
        logic [8:0]  w;
        logic [4:0]  s1;
        logic [3:0]  s2;
        begin
            if (month <= 4'd2)
            begin
                m = month + 4'd12;
                y = year - 12'd1;
            end
            else
            begin
                m = month;
                y = year;
            end
            if (y >= 12'd2100)
            begin
                c    = 5'd21;
                base = 12'd2100;
            end
            else if (y >= 12'd2000)
            begin
                c    = 5'd20;
                base = 12'd2000;
            end
            else if (y >= 12'd1900)
            begin
                c    = 5'd19;
                base = 12'd1900;
            end
            else
            begin
                c    = 5'd18;
                base = 12'd1800;
            end
            yy = 7'(y - base);
            w  = 9'(day) + 9'(ZELLER_MONTH[m]) + 9'(yy) + 9'(yy >> 2)
               + 9'(c >> 2) + 9'({c, 2'b00}) + 9'(c);
            // Since 8 = 1 mod 7, octal digits can be summed.
            s1 = 5'(w[8:6]) + 5'(w[5:3]) + 5'(w[2:0]);
            s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
            if (s2 >= 4'd7)
                return 3'(s2 - 4'd7);
            return s2[2:0];
        end
    endfunction

endpackage

>>> rtl/cds_if.sv
// ----------------------------------------------------------------------------
// Calendar date stepper channels
// Valid/ready channels for requests into the block and results out of it.
// ----------------------------------------------------------------------------
interface cds_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [5:0]  day_in;
    logic [9:0]  day_count;

    modport source (output valid, req_type, year_in, month_in, day_in, day_count,
                    input ready);
    modport sink   (input valid, req_type, year_in, month_in, day_in, day_count,
                    output ready);
endinterface

interface cds_rsp_if;
    logic        valid;
    logic        ready;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [2:0]  weekday;
    logic [2:0]  status;
    logic [1:0]  relation;

    modport source (output valid, year_out, month_out, day_out, weekday, status,
                    relation, input ready);
    modport sink   (input valid, year_out, month_out, day_out, weekday, status,
                    relation, output ready);
endinterface

>>> rtl/cds_ctrl.sv
// ----------------------------------------------------------------------------
// Calendar date stepper controller
// Sequences each request: capture, execute or walk day by day, then hand the
// result to the output register.
// ----------------------------------------------------------------------------
module cds_ctrl
    import cds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if ((stat.op == OP_FWD) || (stat.op == OP_BACK))
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_WALK:
            begin
                if (stat.steps_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.walk = 1'b1;
                    if (stat.blocked)
                        state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/cds_dp.sv
// ----------------------------------------------------------------------------
// Calendar date stepper datapath
// Date registers, request capture, set validation, one-day step logic,
// compare, weekday and the result register.
// ----------------------------------------------------------------------------
module cds_dp
    import cds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    output dp_stat_t    stat,
    input  logic [1:0]  req_type,
    input  logic [11:0] year_in,
    input  logic [3:0]  month_in,
    input  logic [5:0]  day_in,
    input  logic [9:0]  day_count,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [11:0] year_out,
    output logic [3:0]  month_out,
    output logic [4:0]  day_out,
    output logic [2:0]  weekday,
    output logic [2:0]  status,
    output logic [1:0]  relation
);

    // Stored date and walk counter.
    logic [11:0] cur_year_reg,   cur_year_next;
    logic [3:0]  cur_month_reg,  cur_month_next;
    logic [4:0]  cur_day_reg,    cur_day_next;
    logic [9:0]  steps_left_reg, steps_left_next;
    status_t     status_reg,     status_next;
    rel_t        relation_reg,   relation_next;

    // Captured request.
    op_t         op_reg;
    logic [11:0] year_in_reg;
    logic [3:0]  month_in_reg;
    logic [5:0]  day_in_reg;

    // Result register.
    logic        out_valid_reg;
    logic [11:0] year_out_reg;
    logic [3:0]  month_out_reg;
    logic [4:0]  day_out_reg;
    logic [2:0]  weekday_reg;
    status_t     status_out_reg;
    rel_t        relation_out_reg;

    logic [4:0]  cur_dim;
    logic [4:0]  prev_dim;
    logic [4:0]  set_dim;
    logic        blocked;

    // Month lengths for the step and set paths.
    assign cur_dim  = days_in(cur_year_reg, cur_month_reg);
    assign prev_dim = days_in(cur_year_reg, cur_month_reg - 4'd1);
    assign set_dim  = days_in(year_in_reg, month_in_reg);

    // The next day in the walk direction would leave the year range.
    always_comb
    begin
        if (op_reg == OP_FWD)
            blocked = (cur_day_reg >= cur_dim) && (cur_month_reg >= 4'd12)
                   && (cur_year_reg >= YEAR_MAX);
        else
            blocked = (cur_day_reg <= 5'd1) && (cur_month_reg <= 4'd1)
                   && (cur_year_reg <= YEAR_MIN);
    end

    assign stat.op         = op_reg;
    assign stat.steps_zero = (steps_left_reg == '0);
    assign stat.blocked    = blocked;
    assign stat.out_free   = !out_valid_reg || rsp_ready;

    // Next values of the date, counter, status and relation.
    always_comb
    begin
        cur_year_next   = cur_year_reg;
        cur_month_next  = cur_month_reg;
        cur_day_next    = cur_day_reg;
        steps_left_next = steps_left_reg;
        status_next     = status_reg;
        relation_next   = relation_reg;
        if (cmd.load)
        begin
            status_next     = ST_OK;
            relation_next   = REL_EQ;
            steps_left_next = (day_count > MAX_STEP) ? MAX_STEP : day_count;
        end
        else if (cmd.exec)
        begin
            steps_left_next = '0;
            unique case (op_reg)
                OP_SET:
                begin
                    if ((year_in_reg < YEAR_MIN) || (year_in_reg > YEAR_MAX))
                        status_next = ST_BAD_YEAR;
                    else if ((month_in_reg < 4'd1) || (month_in_reg > 4'd12))
                        status_next = ST_BAD_MONTH;
                    else if ((day_in_reg >= 6'd1) && (day_in_reg <= 6'(set_dim)))
                    begin
                        cur_year_next  = year_in_reg;
                        cur_month_next = month_in_reg;
                        cur_day_next   = day_in_reg[4:0];
                    end
                    else if (day_in_reg > 6'd31)
                        status_next = ST_DAY_OVER;
                    else
                        status_next = ST_DAY_INVALID;
                end
                OP_CMP:
                begin
                    if ({cur_year_reg, cur_month_reg, 1'b0, cur_day_reg}
                        == {year_in_reg, month_in_reg, day_in_reg})
                        relation_next = REL_EQ;
                    else if ({cur_year_reg, cur_month_reg, 1'b0, cur_day_reg}
                             < {year_in_reg, month_in_reg, day_in_reg})
                        relation_next = REL_EARLIER;
                    else
                        relation_next = REL_LATER;
                end
                OP_FWD, OP_BACK:
                begin
                    relation_next = REL_EQ;
                end
            endcase
        end
        else if (cmd.walk)
        begin
            if (blocked)
            begin
                status_next     = ST_RANGE_END;
                steps_left_next = '0;
            end
            else
            begin
                steps_left_next = steps_left_reg - 10'd1;
                if (op_reg == OP_FWD)
                begin
                    if (cur_day_reg < cur_dim)
                        cur_day_next = cur_day_reg + 5'd1;
                    else if (cur_month_reg < 4'd12)
                    begin
                        cur_month_next = cur_month_reg + 4'd1;
                        cur_day_next   = 5'd1;
                    end
                    else
                    begin
                        cur_year_next  = cur_year_reg + 12'd1;
                        cur_month_next = 4'd1;
                        cur_day_next   = 5'd1;
                    end
                end
                else
                begin
                    if (cur_day_reg > 5'd1)
                        cur_day_next = cur_day_reg - 5'd1;
                    else if (cur_month_reg > 4'd1)
                    begin
                        cur_month_next = cur_month_reg - 4'd1;
                        cur_day_next   = prev_dim;
                    end
                    else
                    begin
                        cur_year_next  = cur_year_reg - 12'd1;
                        cur_month_next = 4'd12;
                        cur_day_next   = 5'd31;
                    end
                end
            end
        end
    end

    // Date, counter and status registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_year_reg   <= YEAR_MIN;
            cur_month_reg  <= 4'd1;
            cur_day_reg    <= 5'd1;
            steps_left_reg <= '0;
            status_reg     <= ST_OK;
            relation_reg   <= REL_EQ;
            op_reg         <= OP_SET;
        end
        else
        begin
            cur_year_reg   <= cur_year_next;
            cur_month_reg  <= cur_month_next;
            cur_day_reg    <= cur_day_next;
            steps_left_reg <= steps_left_next;
            status_reg     <= status_next;
            relation_reg   <= relation_next;
            if (cmd.load)
                op_reg <= op_t'(req_type);
        end
    end

    // Captured request fields.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            year_in_reg  <= year_in;
            month_in_reg <= month_in;
            day_in_reg   <= day_in;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload with the weekday of the final date.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            year_out_reg     <= cur_year_reg;
            month_out_reg    <= cur_month_reg;
            day_out_reg      <= cur_day_reg;
            weekday_reg      <= zeller_weekday(cur_year_reg, cur_month_reg, cur_day_reg);
            status_out_reg   <= status_reg;
            relation_out_reg <= relation_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign year_out  = year_out_reg;
    assign month_out = month_out_reg;
    assign day_out   = day_out_reg;
    assign weekday   = weekday_reg;
    assign status    = status_out_reg;
    assign relation  = relation_out_reg;

endmodule

>>> rtl/calendar_date_stepper.sv
// ----------------------------------------------------------------------------
// Calendar date stepper
// Holds one Gregorian date (1900-01-01 to 2100-12-31) and serves set, step
// forward, step backward and compare requests, one result per request.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle. A set or compare request
// goes through the execute and finish states to the output register; a step
// of N days walks one day per clock through the datapath's step logic (N up
// to 1023) and stops early when the walk hits an end of the year range, which
// gives status 5. The next request can be accepted as soon as the result is
// loaded into the output register, even if that result has not yet been
// taken. Each result carries the stored date, its Zeller weekday (0 Saturday
// to 6 Friday), a status code and, for a compare, the relation of the stored
// date to the given one.
module calendar_date_stepper
    import cds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cds_req_if.sink   req,
    cds_rsp_if.source rsp
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Request sequencing.
    cds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Date registers and result register.
    cds_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req_type  (req.req_type),
        .year_in   (req.year_in),
        .month_in  (req.month_in),
        .day_in    (req.day_in),
        .day_count (req.day_count),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .year_out  (rsp.year_out),
        .month_out (rsp.month_out),
        .day_out   (rsp.day_out),
        .weekday   (rsp.weekday),
        .status    (rsp.status),
        .relation  (rsp.relation)
    );

endmodule

>>> rtl/cds_checker.sv
// ----------------------------------------------------------------------------
// Calendar date stepper checker
// Port-level checks on the result channel and the request handshake, bound
// to the top level.
// ----------------------------------------------------------------------------
`include "calendar_date_stepper_defines.svh"

module cds_checker
    import cds_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [11:0] year_out,
    input logic [3:0]  month_out,
    input logic [4:0]  day_out,
    input logic [2:0]  weekday,
    input logic [2:0]  status,
    input logic [1:0]  relation
);

    // A stalled result stays up and unchanged.
    `CDS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(year_out) && $stable(month_out) && $stable(day_out) && $stable(weekday) && $stable(status) && $stable(relation))

    // A shown date always has its year, month and day within the supported ranges.
    `CDS_ASSERT_SAME(a_date_range, rsp_valid, (year_out >= YEAR_MIN) && (year_out <= YEAR_MAX) && (month_out >= 4'd1) && (month_out <= 4'd12) && (day_out >= 5'd1) && (day_out <= 5'd31))

    // Weekday and status stay within their codes.
    `CDS_ASSERT_SAME(a_codes, rsp_valid, (weekday <= 3'd6) && (status <= ST_RANGE_END))

    // Only a compare gives a relation, and a compare always reports ok.
    `CDS_ASSERT_SAME(a_rel_ok, rsp_valid && (relation != REL_EQ), status == ST_OK)

    // The block is busy in the cycle after it accepts a request.
    `CDS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .year_out  (rsp.year_out),
    .month_out (rsp.month_out),
    .day_out   (rsp.day_out),
    .weekday   (rsp.weekday),
    .status    (rsp.status),
    .relation  (rsp.relation)
);

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Calendar date stepper testbench
// Sends set, step and compare requests through the request channel and checks
// every result against a date predictor kept in the bench, with random idle
// cycles on both channels and a watchdog on handshake activity.
// ----------------------------------------------------------------------------
module tb_top;
    import cds_pkg::*;

    localparam int HANG_LIMIT   = 6000;
    localparam int DRAIN_CYCLES = 12;

    // One request as the bench builds it.
    typedef struct {
        op_t         op;
        logic [11:0] year;
        logic [3:0]  month;
        logic [5:0]  day;
        logic [9:0]  count;
    } date_req_t;

    // One predicted result.
    typedef struct {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        status_t     status;
        rel_t        relation;
    } date_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    cds_req_if req ();
    cds_rsp_if rsp ();

    calendar_date_stepper u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Predicted stored date.
    int cal_year;
    int cal_month;
    int cal_day;

    date_rsp_t expected_dates[$];
    date_rsp_t oldest_date;

    int send_gap_pct;
    int sink_stall_pct;
    int mismatch_count;
    int results_checked;
    int quiet_cycles;
    int op_count[4];
    int status_seen[8];

    // Clock, period 20.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Date arithmetic for the predictor
    // ------------------------------------------------------------------------

    function automatic bit leap_year(int y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int month_days(int y, int m);
        case (m)
            2:          return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            1, 3, 5, 7, 8, 10, 12: return 31;
            default:    return 0;
        endcase
    endfunction

    // Zeller weekday, 0 Saturday; January and February belong to the year before.
    function automatic int zeller_day(int y, int m, int d);
        int yy;
        int c;
        if (m <= 2)
        begin
            m = m + 12;
            y = y - 1;
        end
        yy = y % 100;
        c  = y / 100;
        return (d + (13 * (m + 1)) / 5 + yy + yy / 4 + c / 4 + 5 * c) % 7;
    endfunction

    // Applies one accepted request to the predicted date and returns its result.
    function automatic date_rsp_t predict_request(date_req_t r);
        date_rsp_t res;
        int left;
        int stored_word;
        int given_word;
        res.status   = ST_OK;
        res.relation = REL_EQ;
        case (r.op)
            OP_SET:
            begin
                if (r.year < YEAR_MIN || r.year > YEAR_MAX)
                    res.status = ST_BAD_YEAR;
                else if (r.month < 1 || r.month > 12)
                    res.status = ST_BAD_MONTH;
                else if (r.day >= 1 && r.day <= month_days(r.year, r.month))
                begin
                    cal_year  = r.year;
                    cal_month = r.month;
                    cal_day   = r.day;
                end
                else if (r.day > 31)
                    res.status = ST_DAY_OVER;
                else
                    res.status = ST_DAY_INVALID;
            end
            OP_FWD, OP_BACK:
            begin
                left = (r.count > MAX_STEP) ? int'(MAX_STEP) : int'(r.count);
                // Walk one day at a time; a range end stops the walk.
                while (left > 0 && res.status == ST_OK)
                begin
                    if (r.op == OP_FWD)
                    begin
                        if (cal_day < month_days(cal_year, cal_month))
                            cal_day++;
                        else if (cal_month < 12)
                        begin
                            cal_month++;
                            cal_day = 1;
                        end
                        else if (cal_year >= YEAR_MAX)
                            res.status = ST_RANGE_END;
                        else
                        begin
                            cal_year++;
                            cal_month = 1;
                            cal_day   = 1;
                        end
                    end
                    else
                    begin
                        if (cal_day > 1)
                            cal_day--;
                        else if (cal_month > 1)
                        begin
                            cal_month--;
                            cal_day = month_days(cal_year, cal_month);
                        end
                        else if (cal_year <= YEAR_MIN)
                            res.status = ST_RANGE_END;
                        else
                        begin
                            cal_year--;
                            cal_month = 12;
                            cal_day   = 31;
                        end
                    end
                    left--;
                end
            end
            default:
            begin
                // The given date is not validated; fields compare as numbers.
                stored_word = cal_year * 1024 + cal_month * 64 + cal_day;
                given_word  = int'(r.year) * 1024 + int'(r.month) * 64 + int'(r.day);
                if (stored_word == given_word)
                    res.relation = REL_EQ;
                else if (stored_word < given_word)
                    res.relation = REL_EARLIER;
                else
                    res.relation = REL_LATER;
            end
        endcase
        res.year    = 12'(cal_year);
        res.month   = 4'(cal_month);
        res.day     = 5'(cal_day);
        res.weekday = 3'(zeller_day(cal_year, cal_month, cal_day));
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    function automatic date_req_t make_request(op_t op, logic [11:0] y, logic [3:0] m,
                                               logic [5:0] d, logic [9:0] n);
        date_req_t r;
        r.op    = op;
        r.year  = y;
        r.month = m;
        r.day   = d;
        r.count = n;
        return r;
    endfunction

    // Sends one request after a random gap and predicts it once it is accepted.
    task automatic send_request(date_req_t r);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.req_type  <= r.op;
        req.year_in   <= r.year;
        req.month_in  <= r.month;
        req.day_in    <= r.day;
        req.day_count <= r.count;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        expected_dates.push_back(predict_request(r));
        op_count[r.op]++;
    endtask

    // Holds off new requests until every outstanding result has been taken.
    task automatic wait_results_drained();
        if (expected_dates.size() != 0)
        begin
            req.valid <= 1'b0;
            while (expected_dates.size() != 0)
                @(posedge clk);
        end
    endtask

    // Builds one random request, mostly well formed, biased toward edges.
    function automatic date_req_t random_request();
        date_req_t r;
        int pick;
        int sel;
        int last;
        r.op    = op_t'($urandom_range(0, 3));
        r.year  = 12'($urandom_range(0, 4095));
        r.month = 4'($urandom_range(0, 15));
        r.day   = 6'($urandom_range(0, 63));
        r.count = 10'($urandom_range(0, 1023));
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            // Valid set, often next to a range end or in February.
            r.op = OP_SET;
            sel  = $urandom_range(0, 99);
            if (sel < 15)
            begin
                if ($urandom_range(0, 1) != 0)
                begin
                    r.year  = YEAR_MAX;
                    r.month = 4'd12;
                    r.day   = 6'($urandom_range(20, 31));
                end
                else
                begin
                    r.year  = YEAR_MIN;
                    r.month = 4'd1;
                    r.day   = 6'($urandom_range(1, 12));
                end
            end
            else
            begin
                r.year  = (sel < 30) ? 12'd2000 : 12'($urandom_range(YEAR_MIN, YEAR_MAX));
                r.month = (sel < 45) ? 4'd2 : 4'($urandom_range(1, 12));
                last    = month_days(r.year, r.month);
                r.day   = ($urandom_range(0, 9) < 3) ? 6'(last) : 6'($urandom_range(1, last));
            end
        end
        else if (pick < 38)
        begin
            // Set aimed at one rejection check, picked at random.
            r.op = OP_SET;
            sel  = $urandom_range(0, 3);
            if (sel != 0)
                r.year = 12'($urandom_range(YEAR_MIN, YEAR_MAX));
            if (sel == 1)
                r.month = ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(13, 15));
            else if (sel >= 2)
                r.month = 4'($urandom_range(1, 12));
            if (sel == 2)
            begin
                last  = month_days(r.year, r.month);
                r.day = (last == 31) ? 6'd0 : 6'($urandom_range(last + 1, 31));
            end
            else if (sel == 3)
                r.day = 6'($urandom_range(32, 63));
        end
        else if (pick < 78)
        begin
            // Step; most counts are short so the run stays fast.
            r.op = ($urandom_range(0, 1) != 0) ? OP_FWD : OP_BACK;
            sel  = $urandom_range(0, 99);
            if (sel < 80)
                r.count = 10'($urandom_range(0, 40));
            else if (sel < 95)
                r.count = 10'($urandom_range(41, 400));
            else if (sel < 98)
                r.count = 10'($urandom_range(401, 1023));
            else
                r.count = MAX_STEP;
        end
        else
        begin
            // Compare against the stored date, a neighbor of it, or anything.
            r.op = OP_CMP;
            sel  = $urandom_range(0, 9);
            if (sel < 7)
            begin
                r.year  = 12'(cal_year);
                r.month = 4'(cal_month);
                r.day   = 6'(cal_day);
            end
            if (sel >= 3 && sel < 7)
            begin
                case ($urandom_range(0, 5))
                    0:       r.year  = 12'(cal_year + 1);
                    1:       r.year  = 12'(cal_year - 1);
                    2:       r.month = 4'(cal_month + 1);
                    3:       r.month = 4'(cal_month - 1);
                    4:       r.day   = 6'(cal_day + 1);
                    default: r.day   = 6'(cal_day - 1);
                endcase
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    always @(posedge clk)
        rsp.ready <= ($urandom_range(0, 99) >= sink_stall_pct);

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Each taken result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_dates.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                oldest_date = expected_dates.pop_front();
                check_field("year_out", oldest_date.year, rsp.year_out);
                check_field("month_out", oldest_date.month, rsp.month_out);
                check_field("day_out", oldest_date.day, rsp.day_out);
                check_field("weekday", oldest_date.weekday, rsp.weekday);
                check_field("status", oldest_date.status, rsp.status);
                check_field("relation", oldest_date.relation, rsp.relation);
                status_seen[oldest_date.status]++;
                results_checked++;
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", HANG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Set requests: each validation check, its order, and leap February.
    task automatic test_set_validation();
        send_request(make_request(OP_SET, 12'd1899, 4'd6, 6'd15, 10'd0));
        send_request(make_request(OP_SET, 12'd2101, 4'd0, 6'd0, 10'd0));
        send_request(make_request(OP_SET, 12'd2000, 4'd13, 6'd40, 10'd0));
        send_request(make_request(OP_SET, 12'd2000, 4'd0, 6'd5, 10'd0));
        send_request(make_request(OP_SET, 12'd2000, 4'd5, 6'd0, 10'd0));
        send_request(make_request(OP_SET, 12'd2000, 4'd5, 6'd63, 10'd0));
        send_request(make_request(OP_SET, 12'd1900, 4'd2, 6'd29, 10'd0));
        send_request(make_request(OP_SET, 12'd2000, 4'd2, 6'd29, 10'd0));
        send_request(make_request(OP_SET, 12'd2050, 4'd4, 6'd31, 10'd0));
    endtask

    // Steps: both range ends, a zero count, back into leap February, the longest walk.
    task automatic test_step_limits();
        send_request(make_request(OP_SET, YEAR_MAX, 4'd12, 6'd30, 10'd0));
        send_request(make_request(OP_FWD, 12'd0, 4'd0, 6'd0, 10'd5));
        send_request(make_request(OP_BACK, 12'd0, 4'd0, 6'd0, 10'd0));
        send_request(make_request(OP_SET, YEAR_MIN, 4'd1, 6'd2, 10'd0));
        send_request(make_request(OP_BACK, 12'd0, 4'd0, 6'd0, 10'd3));
        send_request(make_request(OP_SET, 12'd2024, 4'd3, 6'd1, 10'd0));
        send_request(make_request(OP_BACK, 12'd0, 4'd0, 6'd0, 10'd1));
        send_request(make_request(OP_SET, 12'd1999, 4'd12, 6'd31, 10'd0));
        send_request(make_request(OP_FWD, 12'd0, 4'd0, 6'd0, MAX_STEP));
    endtask

    // Compares: equal, extreme fields on both sides, and one-field neighbors.
    task automatic test_compare();
        send_request(make_request(OP_CMP, 12'(cal_year), 4'(cal_month), 6'(cal_day), 10'd0));
        send_request(make_request(OP_CMP, 12'd4095, 4'd15, 6'd63, 10'd0));
        send_request(make_request(OP_CMP, 12'd0, 4'd0, 6'd0, 10'd0));
        send_request(make_request(OP_CMP, 12'(cal_year), 4'(cal_month + 1), 6'(cal_day),
                                  10'd0));
        send_request(make_request(OP_CMP, 12'(cal_year), 4'(cal_month), 6'(cal_day - 1),
                                  10'd0));
    endtask

    // Random traffic under one idle mix, with a full drain in the middle and at random points.
    task automatic test_random_traffic(int count, int gap_pct, int stall_pct);
        int i;
        send_gap_pct   = gap_pct;
        sink_stall_pct = stall_pct;
        for (i = 0; i < count; i++)
        begin
            if (i == count / 2 || $urandom_range(0, 99) < 2)
                wait_results_drained();
            send_request(random_request());
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.req_type  = OP_SET;
        req.year_in   = '0;
        req.month_in  = '0;
        req.day_in    = '0;
        req.day_count = '0;
        rsp.ready     = 1'b0;
        send_gap_pct   = 22;
        sink_stall_pct = 53;
        cal_year  = YEAR_MIN;
        cal_month = 1;
        cal_day   = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_set_validation();
        test_step_limits();
        test_compare();
        test_random_traffic(186, 22, 53);
        test_random_traffic(186, 53, 22);
        test_random_traffic(185, 0, 0);

        req.valid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d sets, %0d forward, %0d backward, %0d compares.",
                 results_checked, op_count[OP_SET], op_count[OP_FWD], op_count[OP_BACK],
                 op_count[OP_CMP]);
        $display("Rejected sets %0d, range-end stops %0d, over three idle mixes.",
                 status_seen[ST_BAD_YEAR] + status_seen[ST_BAD_MONTH]
                 + status_seen[ST_DAY_OVER] + status_seen[ST_DAY_INVALID],
                 status_seen[ST_RANGE_END]);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/cds_pkg.sv
rtl/cds_if.sv
rtl/cds_ctrl.sv
rtl/cds_dp.sv
rtl/calendar_date_stepper.sv
rtl/cds_checker.sv
sim/tb_top.sv
